// ----- src/cdq_pkg.sv -----
// cdq_pkg: shared types and constants for the circular deque.
// Command and status codes, FSM states, request and response item structs.
// No dependencies.
package cdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_WIDTH   = 32;
   localparam int OCC_WIDTH     = 5;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_REAR  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      cmd_type                        command;
      logic signed [VALUE_WIDTH-1:0]  push_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]  popped_value;
      status_type                     status;
      logic [OCC_WIDTH-1:0]           occupancy;
      logic signed [VALUE_WIDTH-1:0]  front_value;
      logic signed [VALUE_WIDTH-1:0]  back_value;
   } rsp_type;

endpackage

// ----- src/cdq_ram.sv -----
// cdq_ram: generic single-write, single-read RAM with registered read data.
// Width and depth set by parameters. No dependencies.
module cdq_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/circular_deque.sv -----
// circular_deque: fixed-capacity double-ended queue on a circular RAM.
// Pushes, rejected commands and pops that empty the queue register their
// result in the cycle after acceptance; other pops first read the RAM for
// the new front or back entry, then register the result. Throughput: 1 item
// per cycle unless the result stalls; no command is taken during a RAM read.
// Reset (sync, active high) clears pointers, count and output valid; RAM
// contents are undefined until written and need no clearing pass.
module circular_deque #(
   parameter int  DEPTH = cdq_pkg::DEPTH_DEFAULT,
   localparam int PW    = $clog2(DEPTH),
   localparam int CW    = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cdq_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cdq_pkg::rsp_type rsp
);

   localparam int VW = cdq_pkg::VALUE_WIDTH;

   // control and cached state
   cdq_pkg::state_type     state_ff, state_in;
   logic [PW-1:0]          head_ff, head_in;
   logic [PW-1:0]          tail_ff, tail_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   // payload registers
   logic signed [VW-1:0]   front_ff, front_in;
   logic signed [VW-1:0]   back_ff, back_in;
   logic signed [VW-1:0]   pend_pop_ff, pend_pop_in;
   logic                   pend_front_ff, pend_front_in;
   cdq_pkg::rsp_type       rsp_ff, rsp_in;

   // RAM port signals
   logic                   ram_we;
   logic [PW-1:0]          ram_waddr;
   logic                   ram_re;
   logic [PW-1:0]          ram_raddr;
   logic [VW-1:0]          ram_rdata;

   logic                   accept;
   logic                   is_full;
   logic                   none_held;
   logic                   needs_read;
   logic [PW-1:0]          head_inc, head_dec, tail_inc, tail_dec, tail_dec2;

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
      wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] p);
      wrap_dec = (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
   endfunction

   assign req_ready = (state_ff == cdq_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == CW'(DEPTH));
   assign none_held = (count_ff == '0);
   assign head_inc  = wrap_inc(head_ff);
   assign head_dec  = wrap_dec(head_ff);
   assign tail_inc  = wrap_inc(tail_ff);
   assign tail_dec  = wrap_dec(tail_ff);
   assign tail_dec2 = wrap_dec(tail_dec);

   // a pop that leaves entries behind must fetch the new end entry
   assign needs_read = accept && req.command[1] && (count_ff > CW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cdq_pkg::ST_IDLE: begin
            if (needs_read) state_in = cdq_pkg::ST_READ;
         end
         cdq_pkg::ST_READ: begin
            state_in = cdq_pkg::ST_IDLE;
         end
         default: state_in = cdq_pkg::ST_IDLE;
      endcase
   end

   // datapath: pointer updates, RAM access, result build
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      pend_pop_in   = pend_pop_ff;
      pend_front_in = pend_front_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ram_we        = 1'b0;
      ram_waddr     = head_dec;
      ram_re        = 1'b0;
      ram_raddr     = head_inc;

      unique case (state_ff)
         cdq_pkg::ST_READ: begin
            // finish a pop with the entry just read
            rsp_in.popped_value = pend_pop_ff;
            rsp_in.status       = cdq_pkg::STAT_OK;
            rsp_in.occupancy    = cdq_pkg::OCC_WIDTH'(count_ff);
            if (pend_front_ff) begin
               front_in = ram_rdata;
            end else begin
               back_in  = ram_rdata;
            end
            rsp_in.front_value = pend_front_ff ? ram_rdata : front_ff;
            rsp_in.back_value  = pend_front_ff ? back_ff : ram_rdata;
            rsp_valid_in       = 1'b1;
         end
         cdq_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_in.popped_value = '0;
               rsp_in.status       = cdq_pkg::STAT_OK;
               rsp_in.occupancy    = cdq_pkg::OCC_WIDTH'(count_ff);
               rsp_in.front_value  = front_ff;
               rsp_in.back_value   = back_ff;
               rsp_valid_in        = 1'b1;
               unique case (req.command)
                  cdq_pkg::CMD_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_in.status = cdq_pkg::STAT_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = head_dec;
                        head_in   = head_dec;
                        count_in  = count_ff + CW'(1);
                        front_in  = req.push_value;
                        if (none_held) back_in = req.push_value;
                        rsp_in.occupancy   = cdq_pkg::OCC_WIDTH'(count_ff + CW'(1));
                        rsp_in.front_value = req.push_value;
                        rsp_in.back_value  = none_held ? req.push_value : back_ff;
                     end
                  end
                  cdq_pkg::CMD_PUSH_REAR: begin
                     if (is_full) begin
                        rsp_in.status = cdq_pkg::STAT_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = tail_ff;
                        tail_in   = tail_inc;
                        count_in  = count_ff + CW'(1);
                        back_in   = req.push_value;
                        if (none_held) front_in = req.push_value;
                        rsp_in.occupancy   = cdq_pkg::OCC_WIDTH'(count_ff + CW'(1));
                        rsp_in.front_value = none_held ? req.push_value : front_ff;
                        rsp_in.back_value  = req.push_value;
                     end
                  end
                  cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR: begin
                     if (none_held) begin
                        rsp_in.status      = cdq_pkg::STAT_EMPTY;
                        rsp_in.front_value = '0;
                        rsp_in.back_value  = '0;
                     end else begin
                        count_in         = count_ff - CW'(1);
                        rsp_in.occupancy = cdq_pkg::OCC_WIDTH'(count_ff - CW'(1));
                        if (req.command == cdq_pkg::CMD_POP_FRONT) begin
                           head_in     = head_inc;
                           pend_pop_in = front_ff;
                           ram_raddr   = head_inc;
                        end else begin
                           tail_in     = tail_dec;
                           pend_pop_in = back_ff;
                           ram_raddr   = tail_dec2;
                        end
                        pend_front_in       = (req.command == cdq_pkg::CMD_POP_FRONT);
                        rsp_in.popped_value = pend_pop_in;
                        if (needs_read) begin
                           // result goes out after the RAM read
                           ram_re       = 1'b1;
                           rsp_valid_in = 1'b0;
                        end else begin
                           // last entry removed
                           front_in           = '0;
                           back_in            = '0;
                           rsp_in.front_value = '0;
                           rsp_in.back_value  = '0;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdq_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      back_ff       <= back_in;
      pend_pop_ff   <= pend_pop_in;
      pend_front_ff <= pend_front_in;
      rsp_ff        <= rsp_in;
   end

   cdq_ram #(
      .WIDTH (VW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req.push_value),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- src/cdq_checker.sv -----
// cdq_checker: port-level assertions for circular_deque, bound to the top level.
// Depends on cdq_pkg and the circular_deque port list.
module cdq_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cdq_pkg::rsp_type rsp
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("result item changed while stalled");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // empty queue shows zero ends
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.occupancy == '0) |->
         (rsp.front_value == '0) && (rsp.back_value == '0))
      else $error("empty queue reports nonzero front or back");

   // rejected pop removes nothing
   a_empty_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status == cdq_pkg::STAT_EMPTY) |->
         (rsp.occupancy == '0) && (rsp.popped_value == '0))
      else $error("empty reject with data");

   // single entry is both front and back
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.occupancy == 5'd1) |-> (rsp.front_value == rsp.back_value))
      else $error("single entry front and back differ");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);

// ----- tb/sv/tb_circular_deque.sv -----
// tb_circular_deque: self-checking testbench for the circular deque.
// Drives push/pop items through valid/ready with random idling and checks each
// response against a behavioral deque model. Depends on cdq_pkg and circular_deque.
module tb_circular_deque;

   localparam int DEPTH          = cdq_pkg::DEPTH_DEFAULT;
   localparam int VW             = cdq_pkg::VALUE_WIDTH;
   localparam int OW             = cdq_pkg::OCC_WIDTH;
   localparam int RANDOM_ITEMS   = 1800;
   localparam int HOLD_AFTER     = 700;    // accepted items before the long stall
   localparam int HOLD_CYCLES    = 300;
   localparam int IDLE_LIMIT     = 4000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_REPORTS    = 10;

   localparam logic [31:0] FILL_VALUES [16] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
      32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'h8000_0001,
      32'h7FFF_FFFE, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h00FF_00FF,
      32'hFF00_FF00, 32'h1234_5678, 32'h8765_4321, 32'hC3C3_3C3C
   };

   // Behavioral deque: tracks contents and holds the responses still owed
   class deque_scoreboard;
      logic signed [VW-1:0] slots [DEPTH];
      int          head = 0;
      int          tail = 0;
      int          count = 0;
      cdq_pkg::rsp_type owed_q[$];
      int unsigned n_mismatch = 0;
      int unsigned n_checked = 0;
      int unsigned n_push = 0;
      int unsigned n_pop = 0;
      int unsigned n_full = 0;
      int unsigned n_empty = 0;

      function int ring_prev(int p);
         return (p == 0) ? DEPTH - 1 : p - 1;
      endfunction

      function int ring_next(int p);
         return (p == DEPTH - 1) ? 0 : p + 1;
      endfunction

      // Apply one accepted command and queue the response it should produce
      function void note_request(cdq_pkg::req_type r);
         cdq_pkg::rsp_type e;
         e = '0;
         e.status = cdq_pkg::STAT_OK;
         case (r.command)
            cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR: begin
               n_push++;
               if (count >= DEPTH) begin
                  e.status = cdq_pkg::STAT_FULL;
                  n_full++;
               end else if (r.command == cdq_pkg::CMD_PUSH_FRONT) begin
                  head = ring_prev(head);
                  slots[head] = r.push_value;
                  count++;
               end else begin
                  slots[tail] = r.push_value;
                  tail = ring_next(tail);
                  count++;
               end
            end
            default: begin
               n_pop++;
               if (count == 0) begin
                  e.status = cdq_pkg::STAT_EMPTY;
                  n_empty++;
               end else if (r.command == cdq_pkg::CMD_POP_FRONT) begin
                  e.popped_value = slots[head];
                  head = ring_next(head);
                  count--;
               end else begin
                  tail = ring_prev(tail);
                  e.popped_value = slots[tail];
                  count--;
               end
            end
         endcase
         e.occupancy = count[OW-1:0];
         if (count != 0) begin
            e.front_value = slots[head];
            e.back_value  = slots[ring_prev(tail)];
         end
         owed_q.push_back(e);
      endfunction

      // Compare one response against the oldest owed one
      function void check_response(cdq_pkg::rsp_type r);
         cdq_pkg::rsp_type e;
         if (owed_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
               $display("unexpected response: pop=%0d st=%0d occ=%0d front=%0d back=%0d",
                        r.popped_value, r.status, r.occupancy, r.front_value, r.back_value);
            return;
         end
         e = owed_q.pop_front();
         n_checked++;
         if (r.popped_value !== e.popped_value || r.status !== e.status ||
             r.occupancy !== e.occupancy || r.front_value !== e.front_value ||
             r.back_value !== e.back_value) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS) begin
               $display("mismatch on response %0d:", n_checked);
               $display("  expected pop=%0d st=%0d occ=%0d front=%0d back=%0d",
                        e.popped_value, e.status, e.occupancy, e.front_value,
                        e.back_value);
               $display("  actual   pop=%0d st=%0d occ=%0d front=%0d back=%0d",
                        r.popped_value, r.status, r.occupancy, r.front_value,
                        r.back_value);
            end
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   cdq_pkg::req_type req = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   cdq_pkg::rsp_type rsp;

   deque_scoreboard sb = new;
   int unsigned n_req_accepted = 0;
   int          burst_left = 0;

   circular_deque #(.DEPTH(DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Monitor: responses are checked before the same-edge request is noted
   always @(posedge clock) begin : monitor
      int idle_cycles;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp);
         if (req_valid && req_ready) begin
            sb.note_request(req);
            n_req_accepted <= n_req_accepted + 1;
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("** circular_deque: FAILED **");
            $finish;
         end
      end
   end

   // Receiver: random stall patterns in random-length segments, plus one long hold
   initial begin : receiver
      int  mode;
      int  mode_left;
      int  hold_left;
      int  phase;
      bit  held;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      phase = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         phase++;
         if (!held && n_req_accepted >= HOLD_AFTER) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 250);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 9) != 0);
               default: rsp_ready <= ((phase % 8) >= 3);
            endcase
         end
      end
   end

   function automatic cdq_pkg::req_type make_item(cdq_pkg::cmd_type c, logic [31:0] v);
      cdq_pkg::req_type r;
      r.command = c;
      r.push_value = v;
      return r;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Offer one item and hold it until accepted; idle between bursts
   task automatic offer(input cdq_pkg::req_type item);
      int gap;
      req <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 30);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stimulus
   initial begin : stimulus
      int seg_left;
      int push_pct;
      cdq_pkg::cmd_type c;
      seg_left = 0;
      push_pct = 50;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pops, extremes through both ends, fill to full, full pushes, one pop per end
      offer(make_item(cdq_pkg::CMD_POP_FRONT, 32'h0));
      offer(make_item(cdq_pkg::CMD_POP_REAR, 32'hFFFF_FFFF));
      offer(make_item(cdq_pkg::CMD_PUSH_REAR, 32'h7FFF_FFFF));
      offer(make_item(cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000));
      offer(make_item(cdq_pkg::CMD_POP_REAR, 32'h0));
      offer(make_item(cdq_pkg::CMD_POP_FRONT, 32'h0));
      for (int i = 0; i < DEPTH; i++)
         offer(make_item((i % 2 == 0) ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_REAR,
                         FILL_VALUES[i % 16]));
      offer(make_item(cdq_pkg::CMD_PUSH_FRONT, 32'h1111_1111));
      offer(make_item(cdq_pkg::CMD_PUSH_REAR, 32'h2222_2222));
      offer(make_item(cdq_pkg::CMD_POP_FRONT, 32'h0));
      offer(make_item(cdq_pkg::CMD_POP_REAR, 32'h0));

      // Random: segments with a push bias, so the queue swings between full and empty
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(30, 120);
            case ($urandom_range(0, 4))
               0: push_pct = 10;
               1: push_pct = 30;
               2: push_pct = 50;
               3: push_pct = 70;
               default: push_pct = 90;
            endcase
         end
         seg_left--;
         if ($urandom_range(0, 99) < push_pct)
            c = ($urandom_range(0, 1) == 1) ? cdq_pkg::CMD_PUSH_FRONT
                                            : cdq_pkg::CMD_PUSH_REAR;
         else
            c = ($urandom_range(0, 1) == 1) ? cdq_pkg::CMD_POP_FRONT
                                            : cdq_pkg::CMD_POP_REAR;
         offer(make_item(c, pick_value()));
      end
      req_valid <= 1'b0;

      // Drain
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d commands (%0d pushes, %0d pops), %0d responses checked",
               sb.n_push + sb.n_pop, sb.n_push, sb.n_pop, sb.n_checked);
      $display("     %0d pushes refused as full, %0d pops refused as empty, %0d mismatches",
               sb.n_full, sb.n_empty, sb.n_mismatch);
      if (sb.n_mismatch == 0 && sb.owed_q.size() == 0) begin
         $display("** circular_deque: PASSED **");
      end else begin
         $display("** circular_deque: FAILED **");
      end
      $finish;
   end

endmodule
